// ===== sv/nfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants for the next-fit arena allocator
// Arena geometry, controller commands and datapath status.
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int ArenaBytes  = 8192;
  localparam int HeaderBytes = 16;
  localparam int AddrW       = $clog2(ArenaBytes);
  localparam int ValW        = AddrW + 2;   // room for sums past the arena end
  localparam int WalkW       = AddrW + 1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [ValW-1:0]  val_t;

  // Header-store commands driven by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_SIZE,     // read size of addr
    OP_RD_LINK,     // read link of addr
    OP_RD_LINK0,    // read link of addr; not issued by the controller
    OP_WR_SIZE,
    OP_WR_LINK
  } mem_op_e;

  typedef struct packed {
    mem_op_e  op;
    val_t     addr;
    val_t     wdata;
  } mem_cmd_t;

  typedef struct packed {
    val_t rdata;
  } mem_sts_t;

endpackage

// ===== sv/nfa_header_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_header_mem: header store datapath
// Size and link memories with registered reads. Out-of-arena accesses read 0
// and drop writes. Clears itself after reset, one header per cycle.
// ----------------------------------------------------------------------------
module nfa_header_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nfa_pkg::mem_cmd_t cmd_i,
  output nfa_pkg::mem_sts_t sts_o,
  output logic              clr_done_o
);
  import nfa_pkg::*;

  logic [AddrW-1:0] size_mem [ArenaBytes];
  logic [AddrW-1:0] link_mem [ArenaBytes];
  logic [AddrW:0]   clr_q, clr_d;
  logic             in_range_q;
  logic [AddrW-1:0] rsize_q, rlink_q;
  logic             sel_size_q;
  logic             clearing;
  logic             in_range;
  addr_t            a;
  addr_t            ca;
  addr_t            cs, cl;

  assign clearing   = !clr_q[AddrW];
  assign clr_done_o = !clearing;
  assign in_range   = (cmd_i.addr < val_t'(ArenaBytes));
  assign a          = cmd_i.addr[AddrW-1:0];
  assign ca         = clr_q[AddrW-1:0];

  always_comb begin
    clr_d = clr_q + 1'b1;
    cs = '0;
    cl = '0;
    if (ca == addr_t'(0)) begin
      cl = addr_t'(HeaderBytes);
    end
    if (ca == addr_t'(HeaderBytes)) begin
      cs = addr_t'(ArenaBytes - 2 * HeaderBytes);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      size_mem[ca] <= cs;
      link_mem[ca] <= cl;
    end else begin
      if (cmd_i.op == OP_WR_SIZE && in_range) begin
        size_mem[a] <= cmd_i.wdata[AddrW-1:0];
      end
      if (cmd_i.op == OP_WR_LINK && in_range) begin
        link_mem[a] <= cmd_i.wdata[AddrW-1:0];
      end
    end
    rsize_q    <= size_mem[a];
    rlink_q    <= link_mem[a];
    in_range_q <= in_range;
    sel_size_q <= (cmd_i.op == OP_RD_SIZE);
  end

  always_comb begin
    sts_o.rdata = '0;
    if (in_range_q) begin
      sts_o.rdata = val_t'(sel_size_q ? rsize_q : rlink_q);
    end
  end

endmodule

// ===== sv/nfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_ctrl: allocator sequencer
// Walks the free ring, the physical chain and the back-link chain, issuing
// at most one header read or write per step.
// ----------------------------------------------------------------------------
module nfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 opcode_i,
  input  logic [12:0]          request_size_i,
  input  logic [12:0]          payload_offset_i,
  input  logic                 clr_done_i,
  input  nfa_pkg::mem_sts_t    sts_i,
  output nfa_pkg::mem_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [12:0]          granted_offset_o,
  output logic                 alloc_failed_o
);
  import nfa_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_A_LNK   = 23'd1 << 1,  // cur = link(prev)
    S_A_SZ    = 23'd1 << 2,  // read size(cur)
    S_A_CHK   = 23'd1 << 3,
    S_A_NXT   = 23'd1 << 4,  // cur = link(cur)
    S_U_LNK   = 23'd1 << 5,  // unlink: read link(cur)
    S_U_WR    = 23'd1 << 6,  // link(prev) = link(cur)
    S_U_PSZ   = 23'd1 << 7,  // predecessor walk: read size(p)
    S_U_PNX   = 23'd1 << 8,
    S_U_FIN   = 23'd1 << 9,
    S_C_WSZ   = 23'd1 << 10, // carve: size(nb)=req
    S_C_WLK   = 23'd1 << 11,
    S_C_RLK   = 23'd1 << 12, // read link(nxt)
    S_C_CHK   = 23'd1 << 13,
    S_C_SZ    = 23'd1 << 14,
    S_F_LNK   = 23'd1 << 15, // prev = link(h)
    S_F_TL    = 23'd1 << 16, // taken: read link(prev)
    S_F_T0    = 23'd1 << 17, // taken: read link(0)
    S_F_TCHK  = 23'd1 << 18,
    S_F_RLK   = 23'd1 << 19, // not entered; issues no command
    S_F_W1    = 23'd1 << 20,
    S_F_W2    = 23'd1 << 21,
    S_DONE    = 23'd1 << 22
  } state_e;

  state_e      state_q, state_d;
  val_t        cursor_q, cursor_d;
  val_t        prev_q, prev_d;
  val_t        cur_q, cur_d;
  val_t        p_q, p_d;
  val_t        tmp_q, tmp_d;     // size of cur, or link value
  val_t        lk_q, lk_d;       // link(prev) during taken test
  val_t        req_q, req_d;
  val_t        h_q, h_d;
  logic [WalkW-1:0] steps_q, steps_d;
  logic [12:0] gnt_q, gnt_d;
  logic        fail_q, fail_d;
  logic        last_step;
  logic        is_taken;
  val_t        rd;
  logic [ValW:0] need;

  assign rd        = sts_i.rdata;
  assign busy_o    = (state_q != S_IDLE) || !clr_done_i;
  assign last_step = (steps_q == WalkW'(ArenaBytes - 1));
  assign need      = {1'b0, req_q} + (ValW+1)'(2 * HeaderBytes);

  // taken(prev): lk_q = link(prev), rd = link(0)
  always_comb begin
    if (prev_q == '0)               is_taken = 1'b0;
    else if (lk_q > prev_q)         is_taken = 1'b0;
    else if (lk_q != '0)            is_taken = 1'b1;
    else if (rd > prev_q)           is_taken = 1'b1;
    else                            is_taken = (rd == '0);
  end

  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    p_d      = p_q;
    tmp_d    = tmp_q;
    lk_d     = lk_q;
    req_d    = req_q;
    h_d      = h_q;
    steps_d  = steps_q;
    gnt_d    = gnt_q;
    fail_d   = fail_q;
    cmd_o    = '{op: OP_NONE, addr: '0, wdata: '0};
    done_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && clr_done_i) begin
          req_d   = val_t'(request_size_i);
          steps_d = '0;
          if (!opcode_i) begin
            prev_d  = cursor_q;
            state_d = S_A_LNK;
          end else if (payload_offset_i >= 13'(HeaderBytes)) begin
            h_d     = val_t'(payload_offset_i) - val_t'(HeaderBytes);
            state_d = S_F_LNK;
          end
        end
      end
      // ---------------- allocate ----------------
      S_A_LNK: begin
        cmd_o   = '{op: OP_RD_LINK, addr: prev_q, wdata: '0};
        state_d = S_A_SZ;
      end
      S_A_SZ: begin
        cur_d   = rd;
        cmd_o   = '{op: OP_RD_SIZE, addr: rd, wdata: '0};
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        tmp_d = rd;
        if (rd >= req_q) begin
          fail_d = 1'b0;
          if ({1'b0, rd} < need) begin
            cursor_d = '0;
            state_d  = S_U_LNK;
          end else begin
            cursor_d = cur_q;
            state_d  = S_C_WSZ;
          end
        end else if (&steps_q) begin
          // back at the cursor and even that block is too small
          fail_d  = 1'b1;
          gnt_d   = '0;
          state_d = S_DONE;
        end else begin
          prev_d  = cur_q;
          cmd_o   = '{op: OP_RD_LINK, addr: cur_q, wdata: '0};
          state_d = S_A_NXT;
        end
      end
      S_A_NXT: begin
        cur_d = rd;
        if (rd == cursor_q) begin
          // wrapped: mark the last size check with an all-ones step count
          cmd_o   = '{op: OP_RD_SIZE, addr: rd, wdata: '0};
          steps_d = '1;
          state_d = S_A_CHK;
        end else if (last_step) begin
          fail_d  = 1'b1;
          gnt_d   = '0;
          state_d = S_DONE;
        end else begin
          steps_d = steps_q + 1'b1;
          cmd_o   = '{op: OP_RD_SIZE, addr: rd, wdata: '0};
          state_d = S_A_CHK;
        end
      end
      // unlink whole block
      S_U_LNK: begin
        cmd_o   = '{op: OP_RD_LINK, addr: cur_q, wdata: '0};
        state_d = S_U_WR;
      end
      S_U_WR: begin
        cursor_d = rd;
        cmd_o    = '{op: OP_WR_LINK, addr: prev_q, wdata: rd};
        p_d      = prev_q;
        steps_d  = '0;
        state_d  = S_U_PSZ;
      end
      S_U_PSZ: begin
        if (p_q < cur_q && p_q < val_t'(ArenaBytes) &&
            steps_q < WalkW'(ArenaBytes)) begin
          prev_d  = p_q;
          cmd_o   = '{op: OP_RD_SIZE, addr: p_q, wdata: '0};
          state_d = S_U_PNX;
        end else begin
          state_d = S_U_FIN;
        end
      end
      S_U_PNX: begin
        p_d     = p_q + val_t'(HeaderBytes) + rd;
        steps_d = steps_q + 1'b1;
        state_d = S_U_PSZ;
      end
      S_U_FIN: begin
        cmd_o   = '{op: OP_WR_LINK, addr: cur_q, wdata: prev_q};
        gnt_d   = 13'(cur_q + val_t'(HeaderBytes));
        state_d = S_DONE;
      end
      // carve from top; h_q holds nb
      S_C_WSZ: begin
        h_d     = cur_q + tmp_q - req_q;
        cmd_o   = '{op: OP_WR_SIZE, addr: cur_q + tmp_q - req_q, wdata: req_q};
        state_d = S_C_WLK;
      end
      S_C_WLK: begin
        cmd_o   = '{op: OP_WR_LINK, addr: h_q, wdata: cur_q};
        p_d     = cur_q + val_t'(HeaderBytes) + tmp_q;
        state_d = S_C_RLK;
      end
      S_C_RLK: begin
        cmd_o   = '{op: OP_RD_LINK, addr: p_q, wdata: '0};
        state_d = S_C_CHK;
      end
      S_C_CHK: begin
        if (p_q < val_t'(ArenaBytes) && rd == cur_q) begin
          cmd_o = '{op: OP_WR_LINK, addr: p_q, wdata: h_q};
        end
        state_d = S_C_SZ;
      end
      S_C_SZ: begin
        cmd_o   = '{op: OP_WR_SIZE, addr: cur_q,
                    wdata: tmp_q - req_q - val_t'(HeaderBytes)};
        gnt_d   = 13'(h_q + val_t'(HeaderBytes));
        state_d = S_DONE;
      end
      // ---------------- free ----------------
      S_F_LNK: begin
        cmd_o   = '{op: OP_RD_LINK, addr: h_q, wdata: '0};
        state_d = S_F_TL;
      end
      S_F_TL: begin
        prev_d  = rd;
        cmd_o   = '{op: OP_RD_LINK, addr: rd, wdata: '0};
        state_d = S_F_T0;
      end
      S_F_T0: begin
        lk_d    = rd;
        cmd_o   = '{op: OP_RD_LINK, addr: '0, wdata: '0};
        state_d = S_F_TCHK;
      end
      S_F_TCHK: begin
        if (!is_taken) begin
          tmp_d   = lk_q;
          state_d = S_F_W1;
        end else begin
          prev_d = lk_q;
          if (last_step) begin
            state_d = S_IDLE;
          end else begin
            steps_d = steps_q + 1'b1;
            cmd_o   = '{op: OP_RD_LINK, addr: lk_q, wdata: '0};
            state_d = S_F_T0;
          end
        end
      end
      S_F_RLK: begin
        state_d = S_F_W1;
      end
      S_F_W1: begin
        cmd_o   = '{op: OP_WR_LINK, addr: h_q, wdata: tmp_q};
        state_d = S_F_W2;
      end
      S_F_W2: begin
        cmd_o   = '{op: OP_WR_LINK, addr: prev_q, wdata: h_q};
        state_d = S_IDLE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cursor_q <= '0;
      steps_q  <= '0;
      fail_q   <= 1'b0;
      gnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      steps_q  <= steps_d;
      fail_q   <= fail_d;
      gnt_q    <= gnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q  <= cur_d;
    p_q    <= p_d;
    tmp_q  <= tmp_d;
    lk_q   <= lk_d;
    req_q  <= req_d;
    h_q    <= h_d;
  end

  assign granted_offset_o = fail_q ? 13'd0 : gnt_q;
  assign alloc_failed_o   = fail_q;

endmodule

// ===== sv/next_fit_arena_allocator.sv =====
`timescale 1ns / 1ps
// Completion: an allocate strobes done_o once it has carved the first fitting block or
//   unlinked it whole, after any further ring hops and physical steps, or once the
//   ring walk fails; a free holds busy while it walks back-link hops and strobes no done_o.
// Throughput: one request at a time; after an allocate, the next is taken the cycle after done_o.
// Reset: after rst_ni the header store clears all 8192 header slots (busy high).
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// next_fit_arena_allocator: next-fit allocator over an 8 KiB arena
// Controller sequences header reads and writes; the datapath holds headers.
// ----------------------------------------------------------------------------
module next_fit_arena_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [12:0] request_size_i,
  input  logic [12:0] payload_offset_i,
  output logic        done_o,
  output logic [12:0] granted_offset_o,
  output logic        alloc_failed_o
);
  import nfa_pkg::*;

  mem_cmd_t cmd;
  mem_sts_t sts;
  logic     clr_done;

  // Sequencer: accepts a request when idle and the store is initialized.
  nfa_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .payload_offset_i (payload_offset_i),
    .clr_done_i       (clr_done),
    .sts_i            (sts),
    .cmd_o            (cmd),
    .busy_o           (busy),
    .done_o           (done_o),
    .granted_offset_o (granted_offset_o),
    .alloc_failed_o   (alloc_failed_o)
  );

  // Header store: size and link arrays with registered reads.
  nfa_header_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .clr_done_o (clr_done)
  );

endmodule

// ===== tb/next_fit_arena_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_arena_allocator_tb: self-checking bench for the arena allocator
// Drives allocate and free requests and mirrors the header store in an
// internal model. Each result strobe is checked against the oldest predicted
// grant.
// ----------------------------------------------------------------------------
module next_fit_arena_allocator_tb;
  import nfa_pkg::*;

  localparam bit OpAlloc = 1'b0;
  localparam bit OpFree  = 1'b1;

  // Mirror of the header store; predicts one grant per allocate request.
  class arena_scoreboard;
    int unsigned size_mem[ArenaBytes];
    int unsigned link_mem[ArenaBytes];
    int unsigned cursor;
    bit [12:0]   grant_q[$];
    bit          fail_q[$];
    int          errors;
    int          checked;

    function new();
      foreach (size_mem[i]) begin
        size_mem[i] = 0;
        link_mem[i] = 0;
      end
      link_mem[0]           = HeaderBytes;
      size_mem[HeaderBytes] = ArenaBytes - 2 * HeaderBytes;
      cursor  = 0;
      errors  = 0;
      checked = 0;
    endfunction

    // Out-of-arena reads give 0; out-of-arena writes are dropped.
    function int unsigned hsize(int unsigned h);
      return (h < ArenaBytes) ? size_mem[h] : 0;
    endfunction

    function int unsigned hlink(int unsigned h);
      return (h < ArenaBytes) ? link_mem[h] : 0;
    endfunction

    function void set_size(int unsigned h, int unsigned v);
      if (h < ArenaBytes) size_mem[h] = v;
    endfunction

    function void set_link(int unsigned h, int unsigned v);
      if (h < ArenaBytes) link_mem[h] = v;
    endfunction

    // A header h (not 0) is in use when its back-link is in 1..h, or is 0 while link(0) is 0 or above h.
    function bit in_use(int unsigned h);
      int unsigned lk;
      lk = hlink(h);
      if (h == 0) return 0;
      if (lk > h) return 0;
      if (lk != 0) return 1;
      if (hlink(0) > h) return 1;
      return hlink(0) == 0;
    endfunction

    function void allocate(int unsigned req, output int unsigned got, output bit failed);
      int unsigned prv, cur, steps, sz, nb, nxt, p;
      prv   = cursor;
      cur   = hlink(prv);
      steps = 0;
      failed = 0;
      got    = 0;
      // Walk the ring from the cursor to the first block that fits.
      forever begin
        if (hsize(cur) >= req) break;
        prv = cur;
        cur = hlink(cur);
        if (cur == cursor) break;
        steps++;
        if (steps >= ArenaBytes) begin
          failed = 1;
          return;
        end
      end
      sz = hsize(cur);
      if (sz < req) begin
        failed = 1;
        return;
      end
      if (sz < req + 2 * HeaderBytes) begin
        // Unlink whole; the back-link becomes the physical predecessor.
        p      = prv;
        cursor = hlink(cur);
        set_link(prv, hlink(cur));
        steps = 0;
        while (p < cur && p < ArenaBytes && steps < ArenaBytes) begin
          prv = p;
          p   = p + HeaderBytes + hsize(p);
          steps++;
        end
        set_link(cur, prv);
        got = cur + HeaderBytes;
        return;
      end
      // Carve from the top and patch the physical successor's back-link.
      cursor = cur;
      nb     = cur + sz - req;
      set_size(nb, req);
      set_link(nb, cur);
      nxt = cur + HeaderBytes + hsize(cur);
      if (nxt < ArenaBytes && hlink(nxt) == cur) set_link(nxt, nb);
      set_size(cur, sz - (req + HeaderBytes));
      got = nb + HeaderBytes;
    endfunction

    function void release_block(int unsigned off);
      int unsigned h, prv, steps;
      if (off < HeaderBytes) return;
      h = off - HeaderBytes;
      if (h >= ArenaBytes) return;
      prv   = hlink(h);
      steps = 0;
      while (in_use(prv)) begin
        prv = hlink(prv);
        steps++;
        if (steps >= ArenaBytes) return;
      end
      set_link(h, hlink(prv));
      set_link(prv, h);
    endfunction

    // Note an accepted request; return the grant an allocate will produce.
    function void note_request(bit op, int unsigned req, int unsigned off,
                               output bit [12:0] grant, output bit failed);
      int unsigned got;
      grant  = '0;
      failed = 0;
      if (op == OpFree) begin
        release_block(off);
        return;
      end
      allocate(req, got, failed);
      grant = got[12:0];
      grant_q.push_back(grant);
      fail_q.push_back(failed);
    endfunction

    function void check_grant(bit [12:0] grant, bit failed);
      bit [12:0] exp_grant;
      bit        exp_fail;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual offset %0d failed %0b",
                 $time, grant, failed);
        errors++;
        return;
      end
      exp_grant = grant_q.pop_front();
      exp_fail  = fail_q.pop_front();
      checked++;
      if (grant !== exp_grant) begin
        $display("%0t: granted_offset mismatch: expected %0d, actual %0d",
                 $time, exp_grant, grant);
        errors++;
      end
      if (failed !== exp_fail) begin
        $display("%0t: alloc_failed mismatch: expected %0b, actual %0b",
                 $time, exp_fail, failed);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = 1'b0;
  logic [12:0] request_size_i = '0;
  logic [12:0] payload_offset_i = '0;
  logic        done_o;
  logic [12:0] granted_offset_o;
  logic        alloc_failed_o;

  arena_scoreboard sb = new();
  int unsigned     live_offsets[$];
  int              n_alloc, n_free, n_fail;
  bit              quiet_phase;

  always #1 clk_i = ~clk_i;

  next_fit_arena_allocator u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .opcode_i,
    .request_size_i,
    .payload_offset_i,
    .done_o,
    .granted_offset_o,
    .alloc_failed_o
  );

  // Results cannot be held off: check every strobe as it goes by.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_grant(granted_offset_o, alloc_failed_o);
  end

  // Present one request and hold it until the block is no longer busy. Start stays
  // high on return so that back-to-back requests need no second assignment.
  task automatic issue(bit op, int unsigned req, int unsigned off);
    bit [12:0] grant;
    bit        failed;
    start            <= 1'b1;
    opcode_i         <= op;
    request_size_i   <= req[12:0];
    payload_offset_i <= off[12:0];
    do @(posedge clk_i); while (busy);
    sb.note_request(op, req, off, grant, failed);
    if (op == OpAlloc) begin
      n_alloc++;
      if (failed) n_fail++;
      else if (grant != 0) live_offsets.push_back(grant);
    end else begin
      n_free++;
    end
  endtask

  // Drop start now and then, except in the quiet phase.
  task automatic maybe_idle();
    if (!quiet_phase && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic alloc_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)      issue(OpAlloc, $urandom_range(0, 256), 0);
    else if (r < 85) issue(OpAlloc, $urandom_range(257, 1024), 0);
    else if (r < 93) issue(OpAlloc, $urandom_range(1025, 4096), 0);
    else if (r < 97) issue(OpAlloc, $urandom_range(4097, 8160), 0);
    else             issue(OpAlloc, $urandom_range(8161, 8191), 0);
  endtask

  task automatic free_random();
    int idx;
    idx = $urandom_range(0, live_offsets.size() - 1);
    issue(OpFree, 0, live_offsets[idx]);
    live_offsets.delete(idx);
  endtask

  initial begin
    int unsigned r;
    n_alloc = 0;
    n_free  = 0;
    n_fail  = 0;
    quiet_phase = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold off until the header store has been cleared.
    do @(posedge clk_i); while (busy);

    // Directed: zero size, exact fit, oversized, null and tiny frees.
    issue(OpAlloc, 0, 0);
    issue(OpAlloc, 8191, 0);
    issue(OpFree, 0, 0);
    issue(OpFree, 0, 5);
    issue(OpFree, 0, 15);
    issue(OpAlloc, 100, 0);
    issue(OpAlloc, 8160, 0);
    issue(OpAlloc, 1, 0);
    issue(OpAlloc, 4000, 0);
    issue(OpAlloc, 40, 0);
    issue(OpAlloc, 4000, 0);
    while (live_offsets.size() > 0) free_random();
    issue(OpAlloc, 8160, 0);
    while (live_offsets.size() > 0) free_random();
    issue(OpAlloc, 0, 0);
    issue(OpAlloc, 8161, 0);
    issue(OpAlloc, 8159, 0);

    // Random: mostly well-formed allocate/free traffic, a little noise.
    for (int i = 0; i < 1500; i++) begin
      quiet_phase = (i >= 600 && i < 900);
      if (i == 450) begin
        // Drain everything before going on.
        start <= 1'b0;
        wait (sb.grant_q.size() == 0);
        @(posedge clk_i);
      end
      maybe_idle();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        issue(OpFree, 0, $urandom_range(0, HeaderBytes - 1));
      end else if (live_offsets.size() > 0 &&
                   (r < 45 || live_offsets.size() > 40)) begin
        free_random();
      end else begin
        alloc_random();
      end
    end

    // A free near the arena end, with its header still inside the arena, splices a stray entry into the ring.
    issue(OpFree, 0, 8191);
    for (int i = 0; i < 8; i++) alloc_random();
    start <= 1'b0;

    wait (sb.grant_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d allocates (%0d failed) and %0d frees; %0d grants checked.",
             n_alloc, n_fail, n_free, sb.checked);
    if (sb.errors == 0 && sb.grant_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out waiting for the allocator.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
